>>> rtl/growable_block_pool_allocator_core_assert.svh
// assertion macros for the pool allocator core
`ifndef GROWABLE_BLOCK_POOL_ALLOCATOR_CORE_ASSERT_SVH
`define GROWABLE_BLOCK_POOL_ALLOCATOR_CORE_ASSERT_SVH

// same-cycle implication
`define GBPA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GBPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/gbpa_pkg.sv
`default_nettype none

package gbpa_pkg;

  localparam int HandleW = 7;
  localparam int CountW  = 8;
  localparam int UsedW   = 4;

  typedef enum logic [1:0] {
    ACT_ALLOC   = 2'd0,
    ACT_FREE    = 2'd1,
    ACT_RELEASE = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_EXHAUSTED = 2'd1,
    STATUS_BAD_FREE  = 2'd2
  } status_e;

endpackage

`default_nettype wire

>>> rtl/growable_block_pool_allocator_core.sv
// allocate: the result goes through ST_CUR, ST_POP and ST_LINK when the current block
//   has a free slot, and through the block-head scan in ST_SCAN first when it does not
// free: the block of the handle is found by the block-index subtract loop in ST_FREE
// release all and unused actions: result registered on accept; one word in flight at a time
// rst_ni clears the pool asynchronously to one block in use with its slots chained ascending
// release all returns to the same state directly on accept; no clearing pass is needed
`default_nettype none

`include "growable_block_pool_allocator_core_assert.svh"

module growable_block_pool_allocator_core #(
  parameter int BLOCK_SLOTS = 16,
  parameter int MAX_BLOCKS  = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [6:0] handle_in, [7] zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [6:0] handle_out, [14:7] free_count,
                                      // [18:15] blocks_used, [23:19] zero
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  localparam int NE = MAX_BLOCKS * BLOCK_SLOTS;
  localparam int AW = (NE > 1) ? $clog2(NE) : 1;
  localparam int SW = $clog2(BLOCK_SLOTS + 1);
  localparam int BW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int IW = $clog2(MAX_BLOCKS + 1);
  localparam int XW = (AW > 9) ? AW : 9;

  localparam logic [SW-1:0] LIST_END = SW'(BLOCK_SLOTS);
  localparam logic [XW-1:0] BS_X     = XW'(BLOCK_SLOTS);
  localparam logic [8:0]    BS_N     = 9'(BLOCK_SLOTS);
  localparam logic [IW-1:0] MAX_I    = IW'(MAX_BLOCKS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CUR,
    ST_SCAN,
    ST_POP,
    ST_LINK,
    ST_FREE
  } state_e;

  function automatic logic [7:0] sat_up(input logic [7:0] c, input logic [8:0] n);
    logic [9:0] s;
    s = {2'b00, c} + {1'b0, n};
    return (s > 10'd255) ? 8'hFF : s[7:0];
  endfunction

  function automatic logic [7:0] sat_down(input logic [7:0] c);
    return (c != 8'd0) ? c - 8'd1 : c;
  endfunction

  state_e            state_q;
  logic [IW-1:0]     idx_q;
  logic [XW-1:0]     rem_q;
  logic [XW-1:0]     hin_q;
  logic [SW-1:0]     slot_q;
  logic [AW-1:0]     handle_q;
  logic              lv_rd_q;
  logic [SW-1:0]     link_rd_q;
  logic [SW-1:0]     head_q [MAX_BLOCKS];
  logic [NE-1:0]     lv_q;
  logic [IW-1:0]     used_q;
  logic [BW-1:0]     cur_q;
  logic [7:0]        free_q;

  logic              ov_q;
  logic [AW-1:0]     o_handle_q;
  gbpa_pkg::status_e o_status_q;
  logic [7:0]        o_free_q;
  logic [IW-1:0]     o_used_q;

  logic [SW-1:0]     link_mem [NE];

  logic              in_acc;
  logic              out_acc;
  gbpa_pkg::action_e in_act;
  logic [SW-1:0]     head_rd;
  logic [AW-1:0]     raddr;
  logic              mem_re;
  logic              mem_we;
  logic [AW-1:0]     waddr;
  logic [SW-1:0]     link_val;

  assign s_axis_tready = (state_q == ST_IDLE) && (!ov_q || m_axis_tready);
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;
  assign in_act  = gbpa_pkg::action_e'(s_axis_tuser);

  // single read port on the head table, addressed by the sequencer index
  assign head_rd  = head_q[idx_q[BW-1:0]];
  assign raddr    = AW'(int'(idx_q) * BLOCK_SLOTS + int'(head_rd));
  assign mem_re   = (state_q == ST_POP);
  assign mem_we   = (state_q == ST_FREE) && (idx_q != used_q) && (rem_q < BS_X);
  assign waddr    = hin_q[AW-1:0];
  // a link never written since bring-up still holds the ascending chain
  assign link_val = lv_rd_q ? link_rd_q : slot_q + SW'(1);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      link_mem[waddr] <= head_rd;
    end
    if (mem_re) begin
      link_rd_q <= link_mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      idx_q    <= '0;
      rem_q    <= '0;
      hin_q    <= '0;
      slot_q   <= '0;
      handle_q <= '0;
      lv_rd_q  <= 1'b0;
      for (int b = 0; b < MAX_BLOCKS; b++) begin
        head_q[b] <= (b == 0) ? '0 : LIST_END;
      end
      lv_q       <= '0;
      used_q     <= IW'(1);
      cur_q      <= '0;
      free_q     <= sat_up(8'd0, BS_N);
      ov_q       <= 1'b0;
      o_handle_q <= '0;
      o_status_q <= gbpa_pkg::STATUS_OK;
      o_free_q   <= '0;
      o_used_q   <= '0;
    end else begin
      if (out_acc) begin
        ov_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            hin_q <= XW'(s_axis_tdata[6:0]);
            rem_q <= XW'(s_axis_tdata[6:0]);
            unique case (in_act)
              gbpa_pkg::ACT_ALLOC: begin
                idx_q   <= IW'(cur_q);
                state_q <= ST_CUR;
              end
              gbpa_pkg::ACT_FREE: begin
                idx_q   <= '0;
                state_q <= ST_FREE;
              end
              gbpa_pkg::ACT_RELEASE: begin
                for (int b = 0; b < MAX_BLOCKS; b++) begin
                  head_q[b] <= (b == 0) ? '0 : LIST_END;
                end
                lv_q       <= '0;
                used_q     <= IW'(1);
                cur_q      <= '0;
                free_q     <= sat_up(8'd0, BS_N);
                ov_q       <= 1'b1;
                o_handle_q <= '0;
                o_status_q <= gbpa_pkg::STATUS_OK;
                o_free_q   <= sat_up(8'd0, BS_N);
                o_used_q   <= IW'(1);
              end
              default: begin
                ov_q       <= 1'b1;
                o_handle_q <= '0;
                o_status_q <= gbpa_pkg::STATUS_OK;
                o_free_q   <= free_q;
                o_used_q   <= used_q;
              end
            endcase
          end
        end
        ST_CUR: begin
          if ((IW'(cur_q) < used_q) && (head_rd != LIST_END)) begin
            state_q <= ST_POP;
          end else begin
            idx_q   <= '0;
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (idx_q < used_q) begin
            if (head_rd != LIST_END) begin
              state_q <= ST_POP;
            end else begin
              idx_q <= idx_q + IW'(1);
            end
          end else if (used_q < MAX_I) begin
            // bring the next block into use; idx_q already points at it
            for (int i = 0; i < NE; i++) begin
              if ((i / BLOCK_SLOTS) == int'(used_q)) begin
                lv_q[i] <= 1'b0;
              end
            end
            head_q[used_q[BW-1:0]] <= '0;
            used_q  <= used_q + IW'(1);
            cur_q   <= used_q[BW-1:0];
            free_q  <= sat_up(free_q, BS_N);
            state_q <= ST_POP;
          end else begin
            ov_q       <= 1'b1;
            o_handle_q <= '0;
            o_status_q <= gbpa_pkg::STATUS_EXHAUSTED;
            o_free_q   <= free_q;
            o_used_q   <= used_q;
            state_q    <= ST_IDLE;
          end
        end
        ST_POP: begin
          slot_q   <= head_rd;
          handle_q <= raddr;
          lv_rd_q  <= lv_q[raddr];
          state_q  <= ST_LINK;
        end
        ST_LINK: begin
          head_q[idx_q[BW-1:0]] <= link_val;
          free_q     <= sat_down(free_q);
          ov_q       <= 1'b1;
          o_handle_q <= handle_q;
          o_status_q <= gbpa_pkg::STATUS_OK;
          o_free_q   <= sat_down(free_q);
          o_used_q   <= used_q;
          state_q    <= ST_IDLE;
        end
        ST_FREE: begin
          if (idx_q == used_q) begin
            ov_q       <= 1'b1;
            o_handle_q <= '0;
            o_status_q <= gbpa_pkg::STATUS_BAD_FREE;
            o_free_q   <= free_q;
            o_used_q   <= used_q;
            state_q    <= ST_IDLE;
          end else if (rem_q < BS_X) begin
            // link word goes to memory through mem_we this cycle
            head_q[idx_q[BW-1:0]] <= rem_q[SW-1:0];
            lv_q[waddr] <= 1'b1;
            free_q      <= sat_up(free_q, 9'd1);
            ov_q        <= 1'b1;
            o_handle_q  <= '0;
            o_status_q  <= gbpa_pkg::STATUS_OK;
            o_free_q    <= sat_up(free_q, 9'd1);
            o_used_q    <= used_q;
            state_q     <= ST_IDLE;
          end else begin
            rem_q <= rem_q - BS_X;
            idx_q <= idx_q + IW'(1);
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tuser  = o_status_q;
  assign m_axis_tdata  = {5'd0, 4'(o_used_q), o_free_q, 7'(o_handle_q)};

  `GBPA_ASSERT_NOW(a_busy_not_ready, state_q != ST_IDLE, !s_axis_tready, "ready while busy")
  `GBPA_ASSERT_NOW(a_cur_in_use, 1'b1, IW'(cur_q) < used_q, "current block not in use")
  `GBPA_ASSERT_NOW(a_used_range, 1'b1, used_q != '0 && used_q <= MAX_I, "block count out of range")
  `GBPA_ASSERT_NEXT(a_used_grows_in_scan, state_q != ST_SCAN && !(in_acc && s_axis_tuser == gbpa_pkg::ACT_RELEASE), used_q == $past(used_q), "block count changed outside scan")
  `GBPA_ASSERT_NOW(a_handle_zero_on_error, ov_q && o_status_q != gbpa_pkg::STATUS_OK, o_handle_q == '0, "handle set on error")

endmodule

`default_nettype wire

>>> test/growable_block_pool_allocator_core_test.sv
`timescale 1ns / 1ps

module growable_block_pool_allocator_core_test;

  localparam int BlockSlots = 16;
  localparam int MaxBlocks = 8;
  localparam int HandleW = gbpa_pkg::HandleW;
  localparam int CountW = gbpa_pkg::CountW;
  localparam int UsedW = gbpa_pkg::UsedW;
  localparam logic [4:0] ListEnd = 5'd16;
  localparam logic [1:0] ActUnused = 2'd3;
  localparam int RandomWords = 600;
  localparam int StallLimit = 4000;

  typedef struct packed {
    logic [HandleW-1:0] handle;
    gbpa_pkg::status_e  status;
    logic [CountW-1:0]  count;
    logic [UsedW-1:0]   used;
  } result_t;

  typedef struct {
    logic [1:0]         act;
    logic [HandleW-1:0] h;
    int                 reps;
    bit                 typed;
    result_t            want;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [6:0] handle_in, [7] zero
  logic [1:0]  s_axis_tuser = '0;   // [1:0] action
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // [6:0] handle_out, [14:7] free_count, [18:15] blocks_used
  logic [1:0]  m_axis_tuser;        // [1:0] status

  growable_block_pool_allocator_core #(
    .BLOCK_SLOTS(BlockSlots),
    .MAX_BLOCKS (MaxBlocks)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // shadow copy of the pool
  logic [4:0]        link_ram [MaxBlocks*BlockSlots];
  logic [4:0]        head_of [MaxBlocks];
  logic [UsedW-1:0]  blocks_live;
  logic [2:0]        cur_blk;
  logic [CountW-1:0] free_cnt;

  result_t           pending_results [$];
  logic [HandleW-1:0] live_handles [$];
  int                mismatches = 0;
  int                words_sent = 0;
  int                idle_cycles = 0;
  bit                calm = 1'b0;

  stim_row_t directed_rows [20] = '{
    '{gbpa_pkg::ACT_ALLOC, 7'd0, 1, 1'b1, '{7'd0, gbpa_pkg::STATUS_OK, 8'd15, 4'd1}},
    '{gbpa_pkg::ACT_FREE, 7'd0, 1, 1'b1, '{7'd0, gbpa_pkg::STATUS_OK, 8'd16, 4'd1}},
    '{gbpa_pkg::ACT_FREE, 7'd127, 1, 1'b1, '{7'd0, gbpa_pkg::STATUS_BAD_FREE, 8'd16, 4'd1}},
    '{gbpa_pkg::ACT_FREE, 7'd16, 1, 1'b1, '{7'd0, gbpa_pkg::STATUS_BAD_FREE, 8'd16, 4'd1}},
    '{ActUnused, 7'd127, 1, 1'b1, '{7'd0, gbpa_pkg::STATUS_OK, 8'd16, 4'd1}},
    '{gbpa_pkg::ACT_ALLOC, 7'd0, 16, 1'b0, '0},
    '{gbpa_pkg::ACT_ALLOC, 7'd0, 1, 1'b1, '{7'd16, gbpa_pkg::STATUS_OK, 8'd15, 4'd2}},
    '{gbpa_pkg::ACT_FREE, 7'd5, 1, 1'b0, '0},
    '{gbpa_pkg::ACT_ALLOC, 7'd0, 15, 1'b0, '0},
    '{gbpa_pkg::ACT_ALLOC, 7'd0, 1, 1'b0, '0},
    '{gbpa_pkg::ACT_ALLOC, 7'd0, 100, 1'b0, '0},
    '{gbpa_pkg::ACT_ALLOC, 7'd0, 1, 1'b1, '{7'd0, gbpa_pkg::STATUS_EXHAUSTED, 8'd0, 4'd8}},
    '{gbpa_pkg::ACT_FREE, 7'd127, 1, 1'b1, '{7'd0, gbpa_pkg::STATUS_OK, 8'd1, 4'd8}},
    '{gbpa_pkg::ACT_FREE, 7'd127, 1, 1'b0, '0},
    '{gbpa_pkg::ACT_ALLOC, 7'd0, 3, 1'b0, '0},
    '{gbpa_pkg::ACT_FREE, 7'd0, 2, 1'b0, '0},
    '{gbpa_pkg::ACT_ALLOC, 7'd0, 4, 1'b0, '0},
    '{gbpa_pkg::ACT_RELEASE, 7'd0, 1, 1'b1, '{7'd0, gbpa_pkg::STATUS_OK, 8'd16, 4'd1}},
    '{gbpa_pkg::ACT_ALLOC, 7'd127, 1, 1'b1, '{7'd0, gbpa_pkg::STATUS_OK, 8'd15, 4'd1}},
    '{gbpa_pkg::ACT_FREE, 7'd15, 1, 1'b0, '0}
  };

  function automatic void chain_block(input int b);
    for (int i = 0; i < BlockSlots; i++) link_ram[b*BlockSlots+i] = 5'(i + 1);
    head_of[b] = '0;
  endfunction

  function automatic void add_free(input int n);
    int s;
    s = int'(free_cnt) + n;
    free_cnt = (s > 255) ? 8'd255 : CountW'(s);
  endfunction

  function automatic void pool_reset();
    for (int i = 0; i < MaxBlocks*BlockSlots; i++) link_ram[i] = '0;
    for (int b = 0; b < MaxBlocks; b++) head_of[b] = ListEnd;
    chain_block(0);
    blocks_live = 4'd1;
    cur_blk = '0;
    free_cnt = '0;
    add_free(BlockSlots);
  endfunction

  function automatic result_t pool_step(input logic [1:0] act, input logic [HandleW-1:0] h);
    result_t r;
    int blk;
    int slot;
    logic [HandleW-1:0] idx;
    r = '{handle: '0, status: gbpa_pkg::STATUS_OK, count: '0, used: '0};
    case (act)
      gbpa_pkg::ACT_ALLOC: begin
        blk = MaxBlocks;
        if (cur_blk < blocks_live && head_of[cur_blk] != ListEnd) begin
          blk = cur_blk;
        end else begin
          for (int b = 0; b < MaxBlocks; b++)
            if (b < blocks_live && head_of[b] != ListEnd && blk == MaxBlocks) blk = b;
        end
        // every block in use is full: grow the pool if there is room
        if (blk == MaxBlocks && blocks_live < MaxBlocks) begin
          blk = blocks_live;
          chain_block(blk);
          blocks_live = blocks_live + 1'b1;
          cur_blk = 3'(blk);
          add_free(BlockSlots);
        end
        if (blk == MaxBlocks) begin
          r.status = gbpa_pkg::STATUS_EXHAUSTED;
        end else begin
          slot = head_of[blk];
          if (slot >= BlockSlots) slot = 0;
          idx = HandleW'(blk * BlockSlots + slot);
          r.handle = idx;
          head_of[blk] = link_ram[idx];
          if (free_cnt != 0) free_cnt = free_cnt - 1'b1;
        end
      end
      gbpa_pkg::ACT_FREE: begin
        blk = h / BlockSlots;
        slot = h % BlockSlots;
        if (blk < blocks_live) begin
          link_ram[h] = head_of[blk];
          head_of[blk] = 5'(slot);
          add_free(1);
        end else begin
          r.status = gbpa_pkg::STATUS_BAD_FREE;
        end
      end
      gbpa_pkg::ACT_RELEASE: pool_reset();
      default: ;
    endcase
    r.count = free_cnt;
    r.used = blocks_live;
    return r;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  task automatic push_word(input logic [1:0] act, input logic [HandleW-1:0] h, input bit typed,
                           input result_t want);
    result_t predicted;
    while (!calm && $urandom_range(0, 99) < 28) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, h};
    s_axis_tuser <= act;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predicted = pool_step(act, h);
    pending_results.push_back(typed ? want : predicted);
    if (act == gbpa_pkg::ACT_RELEASE) live_handles.delete();
    else if (act == gbpa_pkg::ACT_ALLOC && predicted.status == gbpa_pkg::STATUS_OK)
      live_handles.push_back(predicted.handle);
    words_sent++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) m_axis_tready <= calm || ($urandom_range(0, 99) >= 28);

  always @(posedge clk_i) begin
    result_t want;
    result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tdata[6:0], gbpa_pkg::status_e'(m_axis_tuser), m_axis_tdata[14:7],
              m_axis_tdata[18:15]};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual handle %0d status %0d count %0d used %0d",
                 $time, got.handle, got.status, got.count, got.used);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("handle_out", want.handle, got.handle);
        check_field("status", want.status, got.status);
        check_field("free_count", want.count, got.count);
        check_field("blocks_used", want.used, got.used);
      end
    end
  end

  // ends the run when neither side moves a word for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == StallLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int phase;
    int pick;
    int idx;
    logic [HandleW-1:0] h;
    pool_reset();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      for (int k = 0; k < directed_rows[i].reps; k++)
        push_word(directed_rows[i].act, directed_rows[i].h, directed_rows[i].typed,
                  directed_rows[i].want);

    // hold off until the pool is quiet, then flood block zero with frees
    wait_drained();
    calm <= 1'b1;
    push_word(gbpa_pkg::ACT_RELEASE, 7'($urandom_range(0, 127)), 1'b0, '0);
    for (int n = 0; n < 245; n++)
      push_word(gbpa_pkg::ACT_FREE, 7'($urandom_range(0, 15)), 1'b0, '0);
    for (int n = 0; n < 10; n++)
      push_word(gbpa_pkg::ACT_ALLOC, 7'($urandom_range(0, 127)), 1'b0, '0);
    calm <= 1'b0;

    while (words_sent < RandomWords) begin
      phase = $urandom_range(0, 9);
      if (phase == 0) begin
        // a slot freed twice links to itself, so allocation never empties it
        push_word(gbpa_pkg::ACT_RELEASE, 7'($urandom_range(0, 127)), 1'b0, '0);
        h = 7'($urandom_range(0, 15));
        push_word(gbpa_pkg::ACT_FREE, h, 1'b0, '0);
        push_word(gbpa_pkg::ACT_FREE, h, 1'b0, '0);
        for (int n = 0; n < 20; n++)
          push_word(gbpa_pkg::ACT_ALLOC, 7'($urandom_range(0, 127)), 1'b0, '0);
      end else if (phase == 1) begin
        for (int n = 0; n < 60; n++)
          push_word(gbpa_pkg::ACT_ALLOC, 7'($urandom_range(0, 127)), 1'b0, '0);
      end else begin
        for (int n = 0; n < 40; n++) begin
          pick = $urandom_range(0, 99);
          if (pick < 55) begin
            push_word(gbpa_pkg::ACT_ALLOC, 7'($urandom_range(0, 127)), 1'b0, '0);
          end else if (pick < 92) begin
            if (live_handles.size() != 0 && $urandom_range(0, 9) < 7) begin
              idx = $urandom_range(0, live_handles.size() - 1);
              h = live_handles[idx];
              live_handles.delete(idx);
            end else begin
              h = 7'($urandom_range(0, 127));
            end
            push_word(gbpa_pkg::ACT_FREE, h, 1'b0, '0);
          end else if (pick < 97) begin
            push_word(ActUnused, 7'($urandom_range(0, 127)), 1'b0, '0);
          end else begin
            push_word(gbpa_pkg::ACT_RELEASE, 7'($urandom_range(0, 127)), 1'b0, '0);
          end
        end
      end
    end

    wait_drained();
    repeat (MaxBlocks + 8) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d expected words never arrived", $time, pending_results.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/gbpa_pkg.sv
rtl/growable_block_pool_allocator_core.sv
test/growable_block_pool_allocator_core_test.sv
